FILE: rtl/gda_pkg.sv
// ============================================================================
// Gregorian date adder package
// Shared types, codes and calendar helpers for the date adder block.
// ============================================================================
`default_nettype none

package gda_pkg;

    // Largest year that the date fields can carry.
    localparam logic [14:0] YEAR_MAX = 15'h7FFF;

    // Length of the Gregorian leap cycle in years.
    localparam int YEAR_CYCLE = 400;

    // Operation selected by the mode field.
    typedef enum logic [1:0] {
        MODE_DAYS   = 2'd0,
        MODE_WEEKS  = 2'd1,
        MODE_MONTHS = 2'd2,
        MODE_YEARS  = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // Working date, with the year also kept modulo the leap cycle.
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        logic [8:0]  r400;
    } date_t;

    // Leap rule from the year modulo 400: divisible by 4 but not by 100,
    // or divisible by 400.
    function automatic logic is_leap(input logic [8:0] r400);
        return (r400[1:0] == 2'b00) &&
               (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
    endfunction

    // Month length; months outside 1..12 have no days.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gregorian_date_adder_unit.sv
// ============================================================================
// Gregorian date adder
// Adds days, weeks, months or years to a start date, one day or one month
// per cycle through a shared step unit.
// ============================================================================
// Sequence: the year is reduced modulo 400 by restoring steps, a check state
//   follows, then one day or month is stepped per cycle (amount, 7 x amount
//   or amount steps). Years mode and invalid dates skip the step loop.
// Flow: a new word is taken only back in idle, after the finish state has
//   registered the last result; an output stall holds the finish state.
// Reset: aresetn (synchronous, active low) idles the sequencer and drops m_tvalid.
`default_nettype none

module gregorian_date_adder_unit #(
    parameter int MAX_AMOUNT = 4095
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: mode[1:0], start_day[6:2], start_month[10:7],
    //          start_year[25:11], amount[37:26], zero fill[39:38]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata: end_day[4:0], end_month[8:5], end_year[23:9],
    //          status[25:24], zero fill[31:26]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);
    import gda_pkg::*;

    localparam int AMT_LIM = (MAX_AMOUNT < 4095) ? MAX_AMOUNT : 4095;
    localparam int AMT_W   = $clog2(AMT_LIM + 1);
    localparam int CNT_W   = $clog2(AMT_LIM * 7 + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MODRED,
        S_CHECK,
        S_RUN,
        S_FINISH
    } state_t;

    state_t            state_reg;
    date_t             date_reg;
    mode_t             mode_reg;
    status_t           status_reg;
    logic [AMT_W-1:0]  amt_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [14:0]       rem_reg;
    logic [2:0]        k_reg;
    logic              m_tvalid_reg;
    logic [31:0]       m_tdata_reg;

    logic [11:0]       in_amount;
    logic [AMT_W-1:0]  amt_next;
    logic [CNT_W-1:0]  cnt_next;
    logic [14:0]       mod_div;
    logic [14:0]       rem_next;
    logic              start_ok;
    logic [15:0]       year_sum;
    date_t             date_next;
    logic              step_ovf;

    // Amount, limited to the configured maximum.
    assign in_amount = s_tdata[37:26];
    assign amt_next  = (32'(in_amount) > MAX_AMOUNT) ? AMT_W'(AMT_LIM) : AMT_W'(in_amount);

    // Step count: weeks take seven day steps each.
    assign cnt_next = (mode_reg == MODE_WEEKS) ?
                      CNT_W'({amt_reg, 3'b000}) - CNT_W'(amt_reg) : CNT_W'(amt_reg);

    // One restoring step of the year reduction modulo 400.
    assign mod_div  = 15'(YEAR_CYCLE) << k_reg;
    assign rem_next = (rem_reg >= mod_div) ? rem_reg - mod_div : rem_reg;

    // Start date check and the years-mode sum.
    assign start_ok = (date_reg.day != 5'd0) &&
                      (date_reg.day <= days_in(date_reg.month, is_leap(date_reg.r400)));
    assign year_sum = 16'(date_reg.year) + 16'(amt_reg);

    // Shared day or month step.
    gda_step u_step (
        .cur        (date_reg),
        .month_mode (mode_reg == MODE_MONTHS),
        .nxt        (date_next),
        .ovf        (step_ovf)
    );

    // Sequencer with its registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The finish state drives m_tvalid_reg itself in its own cycle.
            if (m_tvalid_reg && m_tready && (state_reg != S_FINISH)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg      <= mode_t'(s_tdata[1:0]);
                        date_reg.day   <= s_tdata[6:2];
                        date_reg.month <= s_tdata[10:7];
                        date_reg.year  <= s_tdata[25:11];
                        date_reg.r400  <= 9'd0;
                        amt_reg       <= amt_next;
                        rem_reg       <= s_tdata[25:11];
                        k_reg         <= 3'd6;
                        status_reg    <= ST_OK;
                        state_reg     <= S_MODRED;
                    end
                end
                S_MODRED: begin
                    rem_reg <= rem_next;
                    k_reg   <= k_reg - 3'd1;
                    if (k_reg == 3'd0) begin
                        date_reg.r400 <= rem_next[8:0];
                        state_reg     <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    cnt_reg <= cnt_next;
                    if (!start_ok) begin
                        status_reg <= ST_INVALID;
                        state_reg  <= S_FINISH;
                    end else if (mode_reg == MODE_YEARS) begin
                        if (year_sum > 16'(YEAR_MAX)) begin
                            date_reg.year <= YEAR_MAX;
                            status_reg    <= ST_OVERFLOW;
                        end else begin
                            date_reg.year <= year_sum[14:0];
                        end
                        state_reg <= S_FINISH;
                    end else begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (cnt_reg == '0) begin
                        state_reg <= S_FINISH;
                    end else if (step_ovf) begin
                        status_reg <= ST_OVERFLOW;
                        state_reg  <= S_FINISH;
                    end else begin
                        date_reg <= date_next;
                        cnt_reg  <= cnt_reg - CNT_W'(1);
                    end
                end
                S_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {6'b000000, status_reg, date_reg.year,
                                         date_reg.month, date_reg.day};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An accepted word starts the year reduction at once.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && (state_reg == S_MODRED))
        else $error("sequencer did not leave idle after accepting a word");

    // The step counter falls by one per completed step.
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) && (cnt_reg != '0) && !step_ovf
        |=> cnt_reg == $past(cnt_reg) - CNT_W'(1))
        else $error("step counter did not decrement");

    // A good result always carries a nonzero day and a month from 1 to 12.
    a_ok_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[25:24] == ST_OK) |->
        (m_tdata[4:0] != 5'd0) && (m_tdata[8:5] != 4'd0) && (m_tdata[8:5] <= 4'd12))
        else $error("result date out of range with ok status");

    // Status never takes the unused code.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[25:24] != 2'b11))
        else $error("result status holds an unused code");

endmodule

`default_nettype wire

FILE: rtl/gda_step.sv
// ============================================================================
// Date step unit
// Advances a date by one day, or by one month with day clamping, and flags
// a step that would carry the year past its maximum.
// ============================================================================
`default_nettype none

module gda_step (
    input  gda_pkg::date_t cur,
    input  logic           month_mode,
    output gda_pkg::date_t nxt,
    output logic           ovf
);
    import gda_pkg::*;

    logic [4:0]  len_cur;
    logic [4:0]  len_new;
    logic        year_wrap;
    logic        roll;
    logic [3:0]  month_roll;
    logic [14:0] year_roll;
    logic [8:0]  r400_roll;

    // Month and year after a month rollover.
    assign len_cur    = days_in(cur.month, is_leap(cur.r400));
    assign year_wrap  = (cur.month == 4'd12);
    assign month_roll = year_wrap ? 4'd1 : cur.month + 4'd1;
    assign year_roll  = year_wrap ? cur.year + 15'd1 : cur.year;
    assign r400_roll  = !year_wrap ? cur.r400 :
                        (cur.r400 == 9'(YEAR_CYCLE - 1)) ? 9'd0 : cur.r400 + 9'd1;
    assign len_new    = days_in(month_roll, is_leap(r400_roll));

    // A month step always rolls the month; a day step only at month end.
    assign roll = month_mode || (cur.day >= len_cur);
    assign ovf  = roll && year_wrap && (cur.year == YEAR_MAX);

    always_comb begin
        nxt = cur;
        if (roll) begin
            nxt.month = month_roll;
            nxt.year  = year_roll;
            nxt.r400  = r400_roll;
            if (month_mode) begin
                nxt.day = (cur.day > len_new) ? len_new : cur.day;
            end else begin
                nxt.day = 5'd1;
            end
        end else begin
            nxt.day = cur.day + 5'd1;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/gregorian_date_adder_unit_tb.sv
// ============================================================================
// Gregorian date adder testbench
// Drives start dates, modes and amounts into the date adder over the input
// stream and checks every result word against a calendar predictor kept in
// the bench. Directed tests cover leap rules, month and year rollover, day
// clamping, year overflow and invalid dates. A random test follows with
// mostly valid dates and a share of malformed words. Both stream sides idle
// at random.
// ============================================================================
`timescale 1ns / 1ps

module gregorian_date_adder_unit_tb;

    import gda_pkg::*;

    localparam int unsigned AMOUNT_LIMIT = 4095;

    // One expected or observed result word.
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [14:0] year;
        status_t     status;
    } date_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata: mode, start_day, start_month, start_year, amount, zero fill
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata: end_day, end_month, end_year, status, zero fill
    logic [31:0] m_tdata;

    // Dates still owed by the block, oldest first.
    date_result_t pending_dates[$];
    int unsigned  mismatch_count = 0;
    // When set, neither side idles between words.
    logic         steady_flow = 1'b0;

    gregorian_date_adder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------------

    function automatic logic leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic date_result_t add_to_date(input mode_t mode, input logic [4:0] day,
                                                 input logic [3:0] month,
                                                 input logic [14:0] year,
                                                 input logic [11:0] amount);
        int unsigned  d, m, y, n, steps, i;
        date_result_t r;
        d = day;
        m = month;
        y = year;
        n = amount;
        r.status = ST_OK;
        if (n > AMOUNT_LIMIT)
            n = AMOUNT_LIMIT;

        if (m < 1 || m > 12 || d == 0 || d > month_days(m, y)) begin
            r.status = ST_INVALID;
        end else if (mode == MODE_YEARS) begin
            // Year addition saturates and never clamps the day.
            if (y + n > YEAR_MAX) begin
                y = YEAR_MAX;
                r.status = ST_OVERFLOW;
            end else begin
                y = y + n;
            end
        end else if (mode == MODE_MONTHS) begin
            // Month stepping clamps the day at every month it reaches.
            for (i = 0; i < n && r.status == ST_OK; i++) begin
                if (m == 12) begin
                    if (y >= YEAR_MAX)
                        r.status = ST_OVERFLOW;
                    else begin
                        m = 1;
                        y = y + 1;
                    end
                end else begin
                    m = m + 1;
                end
                if (r.status == ST_OK && d > month_days(m, y))
                    d = month_days(m, y);
            end
        end else begin
            // Day stepping; a week is seven days.
            steps = (mode == MODE_WEEKS) ? n * 7 : n;
            for (i = 0; i < steps && r.status == ST_OK; i++) begin
                if (d >= month_days(m, y)) begin
                    if (m == 12) begin
                        if (y >= YEAR_MAX)
                            r.status = ST_OVERFLOW;
                        else begin
                            y = y + 1;
                            m = 1;
                            d = 1;
                        end
                    end else begin
                        m = m + 1;
                        d = 1;
                    end
                end else begin
                    d = d + 1;
                end
            end
        end

        r.day   = d[4:0];
        r.month = m[3:0];
        r.year  = y[14:0];
        return r;
    endfunction

    function automatic int unsigned idle_cycles();
        return steady_flow ? 0 : $urandom_range(0, 9);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: send one word and record the date it should produce.
    // ------------------------------------------------------------------------

    task automatic send_date(input mode_t mode, input logic [4:0] day,
                             input logic [3:0] month, input logic [14:0] year,
                             input logic [11:0] amount);
        int unsigned gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, amount, year, month, day, mode};
        do @(posedge aclk); while (s_tready !== 1'b1);
        pending_dates.push_back(add_to_date(mode, day, month, year, amount));
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall at random, then compare each word with the oldest
    // pending date.
    // ------------------------------------------------------------------------

    initial begin : date_checker
        int unsigned  stall;
        date_result_t seen, want;
        forever begin
            stall = idle_cycles();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk);
            while (!(aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1));

            seen.day    = m_tdata[4:0];
            seen.month  = m_tdata[8:5];
            seen.year   = m_tdata[23:9];
            seen.status = status_t'(m_tdata[25:24]);
            if (pending_dates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result word with no date pending: %0d-%0d-%0d status %0d",
                             $realtime, seen.year, seen.month, seen.day, seen.status);
            end else begin
                want = pending_dates.pop_front();
                if (seen.day !== want.day || seen.month !== want.month ||
                    seen.year !== want.year || seen.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected %0d-%0d-%0d status %0d, got %0d-%0d-%0d status %0d",
                                 $realtime, want.year, want.month, want.day, want.status,
                                 seen.year, seen.month, seen.day, seen.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Leap rules, month and year rollover, zero and full amounts, overflow.
    task automatic test_add_days();
        steady_flow = 1'b0;
        send_date(MODE_DAYS, 5'd28, 4'd2, 15'd2024, 12'd1);
        send_date(MODE_DAYS, 5'd28, 4'd2, 15'd1900, 12'd1);
        send_date(MODE_DAYS, 5'd28, 4'd2, 15'd2000, 12'd1);
        send_date(MODE_DAYS, 5'd31, 4'd12, 15'd1999, 12'd1);
        send_date(MODE_DAYS, 5'd15, 4'd6, 15'd2010, 12'd0);
        send_date(MODE_DAYS, 5'd1, 4'd1, 15'd0, 12'd4095);
        send_date(MODE_DAYS, 5'd31, 4'd12, 15'd32767, 12'd1);
        send_date(MODE_DAYS, 5'd30, 4'd12, 15'd32767, 12'd5);
    endtask

    task automatic test_add_weeks();
        steady_flow = 1'b1;
        send_date(MODE_WEEKS, 5'd25, 4'd12, 15'd2023, 12'd1);
        send_date(MODE_WEEKS, 5'd1, 4'd1, 15'd2000, 12'd4095);
        send_date(MODE_WEEKS, 5'd1, 4'd12, 15'd32767, 12'd10);
    endtask

    // Clamping into February and its accumulation over later months.
    task automatic test_add_months();
        steady_flow = 1'b0;
        send_date(MODE_MONTHS, 5'd31, 4'd1, 15'd2023, 12'd1);
        send_date(MODE_MONTHS, 5'd31, 4'd1, 15'd2023, 12'd2);
        send_date(MODE_MONTHS, 5'd29, 4'd2, 15'd2024, 12'd12);
        send_date(MODE_MONTHS, 5'd15, 4'd12, 15'd32767, 12'd1);
        send_date(MODE_MONTHS, 5'd30, 4'd11, 15'd32500, 12'd4095);
        send_date(MODE_MONTHS, 5'd10, 4'd3, 15'd5, 12'd0);
    endtask

    // Leap day carried into a common year, saturation at the top year.
    task automatic test_add_years();
        steady_flow = 1'b1;
        send_date(MODE_YEARS, 5'd29, 4'd2, 15'd2024, 12'd1);
        send_date(MODE_YEARS, 5'd31, 4'd12, 15'd0, 12'd4095);
        send_date(MODE_YEARS, 5'd1, 4'd1, 15'd32000, 12'd4095);
        send_date(MODE_YEARS, 5'd15, 4'd7, 15'd32767, 12'd0);
    endtask

    // Bad months, day zero, days past the month end.
    task automatic test_invalid_dates();
        steady_flow = 1'b0;
        send_date(MODE_DAYS, 5'd1, 4'd0, 15'd2000, 12'd5);
        send_date(MODE_WEEKS, 5'd31, 4'd15, 15'd32767, 12'd4095);
        send_date(MODE_MONTHS, 5'd0, 4'd6, 15'd2000, 12'd3);
        send_date(MODE_YEARS, 5'd31, 4'd4, 15'd2021, 12'd1);
        send_date(MODE_DAYS, 5'd29, 4'd2, 15'd2023, 12'd1);
        send_date(MODE_MONTHS, 5'd30, 4'd2, 15'd2000, 12'd1);
    endtask

    // Mostly valid dates with small amounts, a few large ones, some noise.
    task automatic test_random_dates(input int unsigned count);
        int unsigned n, y, m, d, amt, len;
        mode_t       mode;
        for (n = 0; n < count; n++) begin
            if (n % 20 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            mode = mode_t'($urandom_range(0, 3));

            // Years anywhere, near the top, near centuries, around today or up to 400.
            case ($urandom_range(0, 4))
                0:       y = $urandom_range(0, 32767);
                1:       y = $urandom_range(32700, 32767);
                2:       y = 100 * $urandom_range(1, 327) - 2 + $urandom_range(0, 4);
                3:       y = $urandom_range(1990, 2110);
                default: y = $urandom_range(0, 400);
            endcase

            // Most amounts stay short so that the run stays short.
            case ($urandom_range(0, 9))
                0:       amt = $urandom_range(0, 4095);
                1, 2:    amt = $urandom_range(0, 1023);
                default: amt = $urandom_range(0, 63);
            endcase

            if ($urandom_range(0, 99) < 15) begin
                d = $urandom_range(0, 31);
                m = $urandom_range(0, 15);
            end else begin
                m = $urandom_range(1, 12);
                len = month_days(m, y);
                case ($urandom_range(0, 3))
                    0:       d = len;
                    1:       d = 1;
                    default: d = $urandom_range(1, len);
                endcase
            end
            send_date(mode, d[4:0], m[3:0], y[14:0], amt[11:0]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_add_days();
        test_add_weeks();
        test_add_months();
        test_add_years();
        test_invalid_dates();
        test_random_dates(113);
        s_tvalid <= 1'b0;

        // Let the last dates drain, then a few spare cycles.
        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Even if every word were 4095 weeks, with the longest stalls the whole
    // run would still finish well within 200 ms.
    initial begin : watchdog
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
